>>> hw/rtl/mtg_pkg.sv
// Shared constants, types and word functions of the Mersenne Twister generator.
`default_nettype none

package mtg_pkg;

    // Table geometry
    localparam int unsigned MT_N     = 624;
    localparam int unsigned MT_M     = 397;
    localparam int unsigned MT_NM    = MT_N - MT_M;
    localparam int unsigned IDX_W    = $clog2(MT_N);
    localparam int unsigned WORD_W   = 32;

    // Recurrence and tempering constants
    localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] MT_UPPER    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'd2636928640;
    localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'd4022730752;
    localparam logic [WORD_W-1:0] SEED_RESET  = 32'd5489;

    localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(MT_N - 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_ISSUE
    } state_t;

    // Control from the sequencer to the table datapath
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr_a;
        idx_t  rd_addr_b;
        logic  seed_start;
        logic  seed_mul;
        logic  seed_add;
        idx_t  seed_idx;
        logic  twist_fire;
        idx_t  twist_addr;
    } dp_ctrl_t;

    // One twist step: upper bit of hi, lower bits of lo, folded with the far word
    function automatic word_t mt_mix(input word_t hi_word, input word_t lo_word,
                                     input word_t far_word);
        word_t y;
        word_t mag;
        y   = (hi_word & MT_UPPER) | (lo_word & MT_LOWER);
        mag = y[0] ? MT_MATRIX : '0;
        return far_word ^ (y >> 1) ^ mag;
    endfunction

    // Output tempering
    function automatic word_t mt_temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mtg_datapath.sv
// State table memory, seeding arithmetic and twist/temper datapath.
`default_nettype none

module mtg_datapath (
    input  wire logic              clk,
    input  wire mtg_pkg::dp_ctrl_t ctrl,
    input  wire mtg_pkg::word_t    seed,
    output mtg_pkg::word_t         value
);
    import mtg_pkg::*;

    word_t mem [MT_N];
    word_t rd_a_reg;
    word_t rd_b_reg;
    word_t head_reg;
    word_t prev_reg;
    word_t prod_reg;
    word_t seed_word;
    word_t twist_word;

    // Next seeded word and next twisted word
    assign seed_word  = prod_reg + WORD_W'(ctrl.seed_idx);
    assign twist_word = mt_mix(head_reg, rd_a_reg, rd_b_reg);
    assign value      = mt_temper(twist_word);

    // Table memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (ctrl.seed_start)
        begin
            mem[0] <= seed;
        end
        else if (ctrl.seed_add)
        begin
            mem[ctrl.seed_idx] <= seed_word;
        end
        else if (ctrl.twist_fire)
        begin
            mem[ctrl.twist_addr] <= twist_word;
        end
        if (ctrl.rd_en)
        begin
            rd_a_reg <= mem[ctrl.rd_addr_a];
            rd_b_reg <= mem[ctrl.rd_addr_b];
        end
    end

    // Hold the current word of the position; seed chain registers
    always_ff @(posedge clk)
    begin
        if (ctrl.seed_start)
        begin
            head_reg <= seed;
            prev_reg <= seed;
        end
        else
        begin
            if (ctrl.twist_fire)
            begin
                head_reg <= rd_a_reg;
            end
            if (ctrl.seed_add)
            begin
                prev_reg <= seed_word;
            end
        end
        if (ctrl.seed_mul)
        begin
            prod_reg <= MT_INIT_MUL * (prev_reg ^ (prev_reg >> 30));
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: stream handshakes, sequencer and seed register.
`default_nettype none

// MT19937 32-bit generator. Each input beat asks for one tempered number and
// yields exactly one output beat. The first beat after reset, and any beat
// with restart set, first refills the 624-word table from the seed register,
// with one multiply and one add per word for 623 words, during which no
// input is taken. Otherwise the table is twisted one word per draw, reading
// the next word and the far word from a dual-read table memory, so numbers
// stream at one per cycle while the output is not stalled; each number
// passes the draw stage and the output register. The seed register takes
// effect only at the next reseed; write it only while the generator is idle.
module mersenne_twister_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import mtg_pkg::*;

    state_t   state_reg;
    state_t   state_next;
    word_t    seed_reg;
    idx_t     pos_reg;
    idx_t     pos_next;
    idx_t     seed_idx_reg;
    logic     seeded_reg;
    logic     s1_valid_reg;
    idx_t     s1_addr_reg;
    logic     out_valid_reg;
    word_t    out_data_reg;
    word_t    dp_value;
    dp_ctrl_t ctrl;
    logic     accept;
    logic     need_seed;
    logic     issue;
    logic     s1_fire;
    logic     cfg_beat;
    logic     in_ready;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign need_seed = s_axis_tdata[0] || !seeded_reg;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue     = (accept && !need_seed) || (state_reg == ST_ISSUE);
    assign pos_next  = (pos_reg == IDX_LAST) ? '0 : pos_reg + 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept && need_seed)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg)
                begin
                    state_next = ST_SEED_MUL;
                end
            end
            ST_SEED_MUL:
            begin
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD:
            begin
                if (seed_idx_reg == IDX_LAST)
                begin
                    state_next = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_SEED_MUL;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready        = (state_reg == ST_RUN) && (!s1_valid_reg || s1_fire);
        ctrl.rd_en      = issue;
        ctrl.rd_addr_a  = pos_next;
        ctrl.rd_addr_b  = (pos_reg < IDX_W'(MT_NM)) ? pos_reg + IDX_W'(MT_M)
                                                     : pos_reg - IDX_W'(MT_NM);
        ctrl.seed_start = (state_reg == ST_DRAIN) && !s1_valid_reg;
        ctrl.seed_mul   = (state_reg == ST_SEED_MUL);
        ctrl.seed_add   = (state_reg == ST_SEED_ADD);
        ctrl.seed_idx   = seed_idx_reg;
        ctrl.twist_fire = s1_fire;
        ctrl.twist_addr = s1_addr_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            seed_reg      <= SEED_RESET;
            pos_reg       <= '0;
            seed_idx_reg  <= '0;
            seeded_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_beat)
            begin
                seed_reg <= cfg_data;
            end
            // Start a reseed: position back to the table head
            if (ctrl.seed_start)
            begin
                seed_idx_reg <= IDX_W'(1);
                seeded_reg   <= 1'b1;
                pos_reg      <= '0;
            end
            else
            begin
                if (ctrl.seed_add)
                begin
                    seed_idx_reg <= seed_idx_reg + 1'b1;
                end
                if (issue)
                begin
                    pos_reg <= pos_next;
                end
            end
            // Draw stage: set on issue, drop when the result moves out
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            // Output beat
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_addr_reg <= pos_reg;
        end
        if (s1_fire)
        begin
            out_data_reg <= dp_value;
        end
    end

    mtg_datapath u_datapath (
        .clk   (clk),
        .ctrl  (ctrl),
        .seed  (seed_reg),
        .value (dp_value)
    );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the MT19937 stream generator: directed draws, then random streams.
`timescale 1ns / 100ps

module testbench;

    import mtg_pkg::word_t;

    // Generator constants for the predictor
    localparam int    WORDS       = 624;
    localparam int    FAR_STEP    = 397;
    localparam word_t INIT_MUL    = 32'd1812433253;
    localparam word_t TWIST_XOR   = 32'd2567483615;
    localparam word_t UPPER_MASK  = 32'h8000_0000;
    localparam word_t LOWER_MASK  = 32'h7fff_ffff;
    localparam word_t TEMPER_B    = 32'd2636928640;
    localparam word_t TEMPER_C    = 32'd4022730752;
    localparam word_t SEED_DFLT   = 32'd5489;

    // Well-known opening outputs for the default seed
    localparam word_t DFLT_DRAW0  = 32'd3499211612;
    localparam word_t DFLT_DRAW1  = 32'd581869302;
    localparam word_t DFLT_DRAW2  = 32'd3890346734;

    localparam int    DIRECTED_ROWS    = 19;
    localparam int    RANDOM_PER_PHASE = 550;
    localparam int    PHASES           = 3;
    localparam int    SETTLE_CYCLES    = 8;

    typedef struct packed {
        logic  load_seed;
        word_t seed_val;
        logic  restart;
        logic  known;
        word_t known_val;
    } draw_row_t;

    // Block ports
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [0] restart, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] value
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = 32'd0;

    // Shadow of the generator state
    word_t       state_words [WORDS];
    int          draw_pos      = WORDS;
    bit          table_filled  = 1'b0;
    word_t       seed_shadow   = SEED_DFLT;

    // Expected numbers in draw order
    word_t       draws_pending [$];
    word_t       want_value;

    int          send_gap_pct  = 29;
    int          recv_gap_pct  = 65;
    int          mismatches    = 0;
    int          draws_sent    = 0;
    int          numbers_seen  = 0;
    int          refills       = 0;
    int          twists        = 0;
    int          seed_writes   = 0;

    // Directed draws: opening outputs, restarts, seed extremes, late seed writes
    draw_row_t directed [DIRECTED_ROWS] = '{
        '{1'b0, 32'd0,         1'b0, 1'b1, DFLT_DRAW0},  // first draw seeds without restart
        '{1'b0, 32'd0,         1'b0, 1'b1, DFLT_DRAW1},
        '{1'b0, 32'd0,         1'b0, 1'b1, DFLT_DRAW2},
        '{1'b0, 32'd0,         1'b1, 1'b1, DFLT_DRAW0},  // restart with same seed
        '{1'b0, 32'd0,         1'b1, 1'b1, DFLT_DRAW0},  // back-to-back restart
        '{1'b1, 32'd0,         1'b0, 1'b1, DFLT_DRAW1},  // new seed waits for restart
        '{1'b0, 32'd0,         1'b1, 1'b0, 32'd0},
        '{1'b0, 32'd0,         1'b0, 1'b0, 32'd0},
        '{1'b1, 32'hffff_ffff, 1'b1, 1'b0, 32'd0},
        '{1'b0, 32'd0,         1'b0, 1'b0, 32'd0},
        '{1'b1, 32'h8000_0000, 1'b1, 1'b0, 32'd0},
        '{1'b1, 32'h0000_0001, 1'b1, 1'b0, 32'd0},
        '{1'b0, 32'd0,         1'b0, 1'b0, 32'd0},
        '{1'b1, 32'h7fff_ffff, 1'b1, 1'b0, 32'd0},
        '{1'b1, SEED_DFLT,     1'b1, 1'b1, DFLT_DRAW0},
        '{1'b0, 32'd0,         1'b0, 1'b1, DFLT_DRAW1},
        '{1'b0, 32'd0,         1'b0, 1'b1, DFLT_DRAW2},
        '{1'b0, 32'd0,         1'b0, 1'b0, 32'd0},
        '{1'b0, 32'd0,         1'b0, 1'b0, 32'd0}
    };

    mersenne_twister_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Advance the shadow generator by one draw and return the tempered number
    function automatic word_t next_tempered(input bit restart);
        int    i;
        word_t y;
        if (restart || !table_filled)
        begin
            state_words[0] = seed_shadow;
            for (i = 1; i < WORDS; i++)
                state_words[i] = INIT_MUL * (state_words[i-1] ^ (state_words[i-1] >> 30))
                                 + word_t'(i);
            draw_pos     = WORDS;
            table_filled = 1'b1;
            refills++;
        end
        if (draw_pos >= WORDS)
        begin
            // Twist in place: late words see the already-updated early words
            for (i = 0; i < WORDS; i++)
            begin
                y = (state_words[i] & UPPER_MASK) | (state_words[(i + 1) % WORDS] & LOWER_MASK);
                state_words[i] = state_words[(i + FAR_STEP) % WORDS] ^ (y >> 1)
                                 ^ (y[0] ? TWIST_XOR : 32'd0);
            end
            draw_pos = 0;
            twists++;
        end
        y = state_words[draw_pos];
        draw_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Pick a seed, leaning on the extremes
    function automatic word_t pick_seed();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return SEED_DFLT;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Hold the input side idle until every expected number has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (draws_pending.size() != 0)
            @(posedge clk);
    endtask

    // Write the seed register while the generator is idle
    task automatic write_seed(input word_t value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        seed_shadow = value;
        seed_writes++;
    endtask

    // Send one draw request beat and queue its expected number
    task automatic send_draw(input bit restart, input bit known, input word_t known_val);
        word_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        predicted = next_tempered(restart);
        draws_pending.push_back(known ? known_val : predicted);
        draws_sent++;
    endtask

    // Output side: random stalls, compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                numbers_seen++;
                if (draws_pending.size() == 0)
                    report_mismatch("unexpected beat", m_axis_tdata, 32'd0);
                else
                begin
                    want_value = draws_pending.pop_front();
                    if (m_axis_tdata !== want_value)
                        report_mismatch("value", m_axis_tdata, want_value);
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int row;
        int phase;
        int n;
        bit restart;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed[row].load_seed)
                write_seed(directed[row].seed_val);
            send_draw(directed[row].restart, directed[row].known, directed[row].known_val);
        end

        // Random streams: long runs between rare restarts
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 29; recv_gap_pct = 65; end
                1: begin send_gap_pct = 65; recv_gap_pct = 29; end
                default: begin send_gap_pct = 0; recv_gap_pct = 0; end
            endcase
            write_seed(pick_seed());
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Drain now and then, sometimes loading a seed that waits for restart
                if ($urandom_range(149) == 0)
                begin
                    wait_drained();
                    if ($urandom_range(1) == 1)
                        write_seed(pick_seed());
                end
                restart = (n == 0) || ($urandom_range(299) == 0);
                send_draw(restart, 1'b0, 32'd0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d draw requests, checked %0d numbers, %0d mismatches.",
                 draws_sent, numbers_seen, mismatches);
        $display("Table refills %0d, full twists %0d, seed writes %0d.",
                 refills, twists, seed_writes);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d numbers still expected.", draws_pending.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_datapath.sv
hw/rtl/mersenne_twister_generator.sv
verif/testbench.sv
